@@ rtl/core/edf_pkg.sv @@
// Shared types and constants for the EDF task scheduler.
// Depends on nothing; used by edf_task_scheduler_unit, edf_chk and the testbench.
package edf_pkg;
	localparam int NUM_TASKS = 16;
	localparam int ADDR_W = $clog2(NUM_TASKS);
	localparam int IDX_W = $clog2(NUM_TASKS + 1);
	localparam int KEY_W = 64;
	localparam int PARAM_W = 40;
	localparam logic [KEY_W-1:0] IDLE_KEY = '1;
	localparam int SM_DECAY_SH = 3;
	localparam int SM_GAIN_SH = 13;
	localparam int SM_INIT_SH = 16;

	typedef enum logic [2:0] {
		K_TICK = 3'd0, K_CREATE = 3'd1, K_DELAY = 3'd2, K_DELETE = 3'd3,
		K_MARK = 3'd4, K_EXIT = 3'd5, K_SWITCH = 3'd6, K_NONE = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0, ST_READY = 2'd1, ST_DELAYED = 2'd2
	} slot_st_t;

	typedef enum logic [2:0] {
		S_IDLE, S_WAKE, S_PICK, S_EXIT, S_FIN
	} fsm_t;
endpackage

@@ rtl/core/edf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module edf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/edf_task_scheduler_unit.sv @@
// EDF task scheduler: per-slot tables in RAM, sequencer scans slots.
// Depends on edf_pkg and edf_ram.
//
// Usage: drive the item fields and raise start; the transaction is taken on
// an edge where start is high and busy is low. Exactly one result follows,
// shown for one cycle with done high; the receiver cannot stall it.
// Steps from accept to done:
//   create, mark entry, held tick, kind 7, ops on idle: finish step only
//   delay with nonzero ticks, delete, switch: a pick scan, then finish
//   exit: the exit step, then a pick scan with a nonzero period, then finish
//   tick: a wake scan, then a pick scan when a wakeup reselects, then finish
// One item at a time; the rate is set by the slot scans, one slot per cycle
// through the key RAM read port. A new item may start in the done cycle.
// Slot keys, deadline parameters, entry and smoothed times live in RAMs;
// slot status and delay bank live in flops that reset clears to free.
// After reset the idle task runs and busy is low at once.
module edf_task_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [3:0]  task_slot,
	input  logic [7:0]  respond_line,
	input  logic [15:0] period_ticks,
	input  logic [15:0] deadline_limit,
	input  logic [15:0] delay_ticks,
	input  logic        hold_wakeups,
	output logic        done,
	output logic [4:0]  current_task,
	output logic        switched,
	output logic [31:0] elapsed_ticks,
	output logic        deadline_miss,
	output logic [31:0] smoothed_time,
	output logic [4:0]  woken_count,
	output logic        error_code
);
	localparam int N = edf_pkg::NUM_TASKS;
	localparam int AW = edf_pkg::ADDR_W;
	localparam int IW = edf_pkg::IDX_W;

	edf_pkg::fsm_t state_q, state_d;
	edf_pkg::slot_st_t status_q [N];
	logic [N-1:0] sbank_q;
	logic [IW-1:0] idx_q, best_q, running_q;
	logic [63:0] cur_key_q, best_key_q, clock_q;
	logic [31:0] cnt_q;
	logic act_bank_q, trig_q;
	logic sw_q, miss_q, err_q, done_q;
	logic [31:0] el_q, sm_q;
	logic [4:0] woken_q;

	logic accept, running;
	edf_pkg::kind_t kd;
	logic [AW-1:0] run_a, eval_a, new_a, raddr;
	logic key_we, ent_we, sm_we, par_we;
	logic [AW-1:0] key_wa, ent_wa, sm_wa;
	logic [63:0] key_wd, key_rd;
	logic [31:0] ent_wd, sm_wd, ent_rd, sm_rd;
	logic [edf_pkg::PARAM_W-1:0] par_rd;
	logic [32:0] wake_sum;
	logic [15:0] sleep_ticks;
	logic [31:0] ex_el, ex_sm;
	logic [63:0] new_key;
	logic ev_wake, ev_pick, scan_end, slot_ok;

	assign accept = start && !busy;
	assign busy = state_q != edf_pkg::S_IDLE;
	assign kd = edf_pkg::kind_t'(kind);
	assign running = running_q < IW'(N);
	assign run_a = AW'(running_q);
	assign eval_a = AW'(idx_q - IW'(1));
	assign new_a = AW'(task_slot);
	assign slot_ok = 32'(task_slot) < 32'(N);
	assign scan_end = idx_q == IW'(N);
	assign raddr = (state_q == edf_pkg::S_IDLE) ? run_a : AW'(idx_q);

	// parameter word: {respond_line, period, deadline_limit}
	assign sleep_ticks = (state_q == edf_pkg::S_EXIT) ? par_rd[31:16] : delay_ticks;
	assign wake_sum = {1'b0, cnt_q} + {17'd0, sleep_ticks};
	assign new_key = clock_q + {56'd0, par_rd[39:32]};
	assign ex_el = clock_q[31:0] - ent_rd;
	assign ex_sm = (sm_rd == 32'd0) ? (ex_el << edf_pkg::SM_INIT_SH)
		: (sm_rd - (sm_rd >> edf_pkg::SM_DECAY_SH)) + (ex_el << edf_pkg::SM_GAIN_SH);
	assign ev_wake = idx_q != '0 && status_q[eval_a] == edf_pkg::ST_DELAYED
		&& sbank_q[eval_a] == act_bank_q && key_rd <= {32'd0, cnt_q};
	assign ev_pick = idx_q != '0 && status_q[eval_a] == edf_pkg::ST_READY
		&& ((best_q == IW'(N)) ? key_rd <= best_key_q : key_rd < best_key_q);

	always_comb begin
		state_d = state_q;
		key_we = 1'b0; key_wa = run_a; key_wd = {32'd0, wake_sum[31:0]};
		ent_we = 1'b0; ent_wa = run_a; ent_wd = clock_q[31:0];
		sm_we = 1'b0; sm_wa = run_a; sm_wd = ex_sm;
		par_we = 1'b0;
		unique case (state_q)
			edf_pkg::S_IDLE: begin
				if (accept) begin
					state_d = edf_pkg::S_FIN;
					unique case (kd)
						edf_pkg::K_TICK: begin
							if (!hold_wakeups) state_d = edf_pkg::S_WAKE;
						end
						edf_pkg::K_CREATE: begin
							if (slot_ok && status_q[new_a] == edf_pkg::ST_FREE) begin
								key_we = 1'b1; key_wa = new_a;
								key_wd = clock_q + {56'd0, respond_line};
								ent_we = 1'b1; ent_wa = new_a; ent_wd = '0;
								sm_we = 1'b1; sm_wa = new_a; sm_wd = '0;
								par_we = 1'b1;
							end
						end
						edf_pkg::K_DELAY: begin
							if (running && delay_ticks != 16'd0) begin
								key_we = 1'b1;
								state_d = edf_pkg::S_PICK;
							end
						end
						edf_pkg::K_DELETE: begin
							if (running) state_d = edf_pkg::S_PICK;
						end
						edf_pkg::K_MARK: begin
							ent_we = running;
						end
						edf_pkg::K_EXIT: begin
							if (running) state_d = edf_pkg::S_EXIT;
						end
						edf_pkg::K_SWITCH: state_d = edf_pkg::S_PICK;
						default: state_d = edf_pkg::S_FIN;
					endcase
				end
			end
			edf_pkg::S_WAKE: begin
				if (ev_wake) begin
					key_we = 1'b1; key_wa = eval_a; key_wd = new_key;
				end
				if (scan_end) begin
					state_d = (trig_q || (ev_wake && new_key <= cur_key_q))
						? edf_pkg::S_PICK : edf_pkg::S_FIN;
				end
			end
			edf_pkg::S_PICK: begin
				if (scan_end) state_d = edf_pkg::S_FIN;
			end
			edf_pkg::S_EXIT: begin
				sm_we = 1'b1;
				if (par_rd[31:16] != 16'd0) begin
					key_we = 1'b1;
					state_d = edf_pkg::S_PICK;
				end else begin
					state_d = edf_pkg::S_FIN;
				end
			end
			edf_pkg::S_FIN: state_d = edf_pkg::S_IDLE;
			default: state_d = edf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) status_q[i] <= edf_pkg::ST_FREE;
			sbank_q <= '0;
			idx_q <= '0;
			best_q <= IW'(N);
			running_q <= IW'(N);
			best_key_q <= edf_pkg::IDLE_KEY;
			cur_key_q <= edf_pkg::IDLE_KEY;
			clock_q <= '0;
			cnt_q <= '0;
			act_bank_q <= 1'b0;
			trig_q <= 1'b0;
			sw_q <= 1'b0; miss_q <= 1'b0; err_q <= 1'b0; done_q <= 1'b0;
			el_q <= '0; sm_q <= '0; woken_q <= '0;
		end else begin
			done_q <= state_q == edf_pkg::S_FIN;
			idx_q <= '0;
			best_q <= IW'(N);
			best_key_q <= edf_pkg::IDLE_KEY;
			unique case (state_q)
				edf_pkg::S_IDLE: begin
					if (accept) begin
						sw_q <= 1'b0; miss_q <= 1'b0; err_q <= 1'b0;
						el_q <= '0; sm_q <= '0; woken_q <= '0;
						trig_q <= 1'b0;
						unique case (kd)
							edf_pkg::K_TICK: begin
								clock_q <= clock_q + 64'd1;
								cnt_q <= cnt_q + 32'd1;
								if (!hold_wakeups && cnt_q == '1) act_bank_q <= ~act_bank_q;
							end
							edf_pkg::K_CREATE: begin
								if (slot_ok && status_q[new_a] == edf_pkg::ST_FREE) begin
									status_q[new_a] <= edf_pkg::ST_READY;
									sbank_q[new_a] <= 1'b0;
								end else begin
									err_q <= 1'b1;
								end
							end
							edf_pkg::K_DELAY: begin
								if (running && delay_ticks != 16'd0) begin
									status_q[run_a] <= edf_pkg::ST_DELAYED;
									sbank_q[run_a] <= act_bank_q ^ wake_sum[32];
									sw_q <= 1'b1;
								end
							end
							edf_pkg::K_DELETE: begin
								if (running) begin
									status_q[run_a] <= edf_pkg::ST_FREE;
									sw_q <= 1'b1;
								end
							end
							edf_pkg::K_SWITCH: sw_q <= 1'b1;
							default: ;
						endcase
					end
				end
				edf_pkg::S_WAKE: begin
					idx_q <= idx_q + IW'(1);
					// first cycle: the running task's key arrives from the RAM
					if (idx_q == '0) cur_key_q <= running ? key_rd : edf_pkg::IDLE_KEY;
					if (ev_wake) begin
						status_q[eval_a] <= edf_pkg::ST_READY;
						woken_q <= woken_q + 5'd1;
						if (new_key <= cur_key_q) trig_q <= 1'b1;
					end
					if (scan_end) begin
						idx_q <= '0;
						if (trig_q || (ev_wake && new_key <= cur_key_q)) sw_q <= 1'b1;
					end
				end
				edf_pkg::S_PICK: begin
					idx_q <= idx_q + IW'(1);
					best_q <= ev_pick ? IW'(eval_a) : best_q;
					best_key_q <= ev_pick ? key_rd : best_key_q;
					if (scan_end) begin
						idx_q <= '0;
						running_q <= ev_pick ? IW'(eval_a) : best_q;
					end
				end
				edf_pkg::S_EXIT: begin
					el_q <= ex_el;
					sm_q <= ex_sm;
					miss_q <= ex_el >= {16'd0, par_rd[15:0]};
					if (par_rd[31:16] != 16'd0) begin
						status_q[run_a] <= edf_pkg::ST_DELAYED;
						sbank_q[run_a] <= act_bank_q ^ wake_sum[32];
						sw_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	edf_ram #(.WIDTH(64), .DEPTH(N)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
		.raddr(raddr), .rdata(key_rd)
	);
	edf_ram #(.WIDTH(32), .DEPTH(N)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
		.raddr(raddr), .rdata(ent_rd)
	);
	edf_ram #(.WIDTH(32), .DEPTH(N)) u_sm_ram (
		.clk(clk), .we(sm_we), .waddr(sm_wa), .wdata(sm_wd),
		.raddr(raddr), .rdata(sm_rd)
	);
	edf_ram #(.WIDTH(edf_pkg::PARAM_W), .DEPTH(N)) u_par_ram (
		.clk(clk), .we(par_we), .waddr(new_a),
		.wdata({respond_line, period_ticks, deadline_limit}),
		.raddr(raddr), .rdata(par_rd)
	);

	assign done = done_q;
	assign current_task = 5'(running_q);
	assign switched = sw_q;
	assign elapsed_ticks = el_q;
	assign deadline_miss = miss_q;
	assign smoothed_time = sm_q;
	assign woken_count = woken_q;
	assign error_code = err_q;
endmodule

@@ rtl/core/edf_chk.sv @@
// Port-level checker for the EDF task scheduler, bound to the top level.
// Depends on edf_pkg and edf_task_scheduler_unit.
module edf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [4:0]  current_task,
	input logic        switched,
	input logic [4:0]  woken_count,
	input logic        error_code
);
	// a taken transaction keeps the unit busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_task_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(current_task) <= 32'(edf_pkg::NUM_TASKS))
		else $error("current task out of range");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && error_code |-> !switched && woken_count == 5'd0)
		else $error("refused create reported other activity");
endmodule

bind edf_task_scheduler_unit edf_chk u_edf_chk (.*);

@@ tb/sv/edf_task_scheduler_unit_tb.sv @@
// Self-checking testbench for the EDF task scheduler unit.
// Depends on edf_pkg and edf_task_scheduler_unit; a directed table, then random traffic.
`timescale 1ns / 1ps
module edf_task_scheduler_unit_tb;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [3:0]  task_slot;
	logic [7:0]  respond_line;
	logic [15:0] period_ticks;
	logic [15:0] deadline_limit;
	logic [15:0] delay_ticks;
	logic        hold_wakeups;
	logic        done;
	logic [4:0]  current_task;
	logic        switched;
	logic [31:0] elapsed_ticks;
	logic        deadline_miss;
	logic [31:0] smoothed_time;
	logic [4:0]  woken_count;
	logic        error_code;

	edf_task_scheduler_unit dut (.*);

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  rline;
		logic [15:0] period;
		logic [15:0] dlimit;
		logic [15:0] dticks;
		logic        hold;
	} sched_cmd_t;

	typedef struct packed {
		logic [4:0]  cur;
		logic        sw;
		logic [31:0] elapsed;
		logic        miss;
		logic [31:0] smooth;
		logic [4:0]  woken;
		logic        err;
	} sched_rsp_t;

	// scheduler shadow state
	edf_pkg::slot_st_t sh_status [edf_pkg::NUM_TASKS];
	logic [63:0] sh_key    [edf_pkg::NUM_TASKS];
	logic        sh_bank   [edf_pkg::NUM_TASKS];
	logic [7:0]  sh_rline  [edf_pkg::NUM_TASKS];
	logic [15:0] sh_period [edf_pkg::NUM_TASKS];
	logic [15:0] sh_dlimit [edf_pkg::NUM_TASKS];
	logic [31:0] sh_entry  [edf_pkg::NUM_TASKS];
	logic [31:0] sh_smooth [edf_pkg::NUM_TASKS];
	logic [63:0] sh_clock;
	logic [31:0] sh_ticks;
	logic        sh_active;
	logic [4:0]  sh_run;

	sched_rsp_t  pending_rsp [$];
	int          fail_cnt = 0;
	longint      cyc = 0;

	function automatic void pick_earliest();
		logic [4:0]  best;
		logic [63:0] bkey;
		best = 5'(edf_pkg::NUM_TASKS);
		bkey = edf_pkg::IDLE_KEY;
		for (int i = 0; i < edf_pkg::NUM_TASKS; i++)
			if (sh_status[i] == edf_pkg::ST_READY &&
			    (best == edf_pkg::NUM_TASKS ? sh_key[i] <= bkey : sh_key[i] < bkey)) begin
				best = 5'(i);
				bkey = sh_key[i];
			end
		sh_run = best;
	endfunction

	function automatic void sleep_running(logic [31:0] n);
		logic [31:0] wake;
		wake = sh_ticks + n;
		sh_status[sh_run] = edf_pkg::ST_DELAYED;
		sh_key[sh_run] = {32'd0, wake};
		sh_bank[sh_run] = (wake < sh_ticks) ? ~sh_active : sh_active;
		pick_earliest();
	endfunction

	function automatic sched_rsp_t schedule_step(sched_cmd_t c);
		sched_rsp_t  r;
		logic        running;
		logic        trig;
		logic [63:0] ck;
		logic [31:0] sm;
		logic [4:0]  s;
		r = '0;
		running = sh_run < edf_pkg::NUM_TASKS;
		s = sh_run;
		case (edf_pkg::kind_t'(c.kind))
			edf_pkg::K_TICK: begin
				sh_clock++;
				sh_ticks++;
				if (!c.hold) begin
					if (sh_ticks == 0) sh_active = ~sh_active;
					ck = running ? sh_key[s] : edf_pkg::IDLE_KEY;
					trig = 0;
					for (int i = 0; i < edf_pkg::NUM_TASKS; i++)
						if (sh_status[i] == edf_pkg::ST_DELAYED && sh_bank[i] == sh_active &&
						    sh_key[i] <= {32'd0, sh_ticks}) begin
							sh_status[i] = edf_pkg::ST_READY;
							sh_key[i] = sh_clock + sh_rline[i];
							r.woken++;
							if (sh_key[i] <= ck) trig = 1;
						end
					if (trig) begin
						pick_earliest();
						r.sw = 1;
					end
				end
			end
			edf_pkg::K_CREATE: begin
				if (sh_status[c.slot] != edf_pkg::ST_FREE) r.err = 1;
				else begin
					sh_rline[c.slot] = c.rline;
					sh_period[c.slot] = c.period;
					sh_dlimit[c.slot] = c.dlimit;
					sh_entry[c.slot] = 0;
					sh_smooth[c.slot] = 0;
					sh_bank[c.slot] = 0;
					sh_status[c.slot] = edf_pkg::ST_READY;
					sh_key[c.slot] = sh_clock + c.rline;
				end
			end
			edf_pkg::K_DELAY: if (running && c.dticks != 0) begin
				sleep_running(c.dticks);
				r.sw = 1;
			end
			edf_pkg::K_DELETE: if (running) begin
				sh_status[s] = edf_pkg::ST_FREE;
				pick_earliest();
				r.sw = 1;
			end
			edf_pkg::K_MARK: if (running) sh_entry[s] = sh_clock[31:0];
			edf_pkg::K_EXIT: if (running) begin
				r.elapsed = sh_clock[31:0] - sh_entry[s];
				sm = sh_smooth[s];
				if (sm != 0)
					sm = (sm - (sm >> edf_pkg::SM_DECAY_SH))
						+ (r.elapsed << edf_pkg::SM_GAIN_SH);
				else sm = r.elapsed << edf_pkg::SM_INIT_SH;
				sh_smooth[s] = sm;
				r.smooth = sm;
				r.miss = r.elapsed >= {16'd0, sh_dlimit[s]};
				if (sh_period[s] != 0) begin
					sleep_running(sh_period[s]);
					r.sw = 1;
				end
			end
			edf_pkg::K_SWITCH: begin
				pick_earliest();
				r.sw = 1;
			end
			default: ;
		endcase
		r.cur = sh_run;
		return r;
	endfunction

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		sched_rsp_t e;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no expectation waiting");
				fail_cnt++;
			end else begin
				e = pending_rsp.pop_front();
				if (current_task !== e.cur) begin
					$error("current_task exp %0d got %0d", e.cur, current_task); fail_cnt++;
				end
				if (switched !== e.sw) begin
					$error("switched exp %0d got %0d", e.sw, switched); fail_cnt++;
				end
				if (elapsed_ticks !== e.elapsed) begin
					$error("elapsed_ticks exp %0h got %0h", e.elapsed, elapsed_ticks); fail_cnt++;
				end
				if (deadline_miss !== e.miss) begin
					$error("deadline_miss exp %0d got %0d", e.miss, deadline_miss); fail_cnt++;
				end
				if (smoothed_time !== e.smooth) begin
					$error("smoothed_time exp %0h got %0h", e.smooth, smoothed_time); fail_cnt++;
				end
				if (woken_count !== e.woken) begin
					$error("woken_count exp %0d got %0d", e.woken, woken_count); fail_cnt++;
				end
				if (error_code !== e.err) begin
					$error("error_code exp %0d got %0d", e.err, error_code); fail_cnt++;
				end
			end
		end
	end

	// present one transaction, wait for acceptance; typed result overrides prediction
	task automatic issue_cmd(sched_cmd_t c, bit typed, sched_rsp_t want);
		sched_rsp_t p;
		kind <= c.kind; task_slot <= c.slot; respond_line <= c.rline;
		period_ticks <= c.period; deadline_limit <= c.dlimit;
		delay_ticks <= c.dticks; hold_wakeups <= c.hold;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		p = schedule_step(c);
		pending_rsp.push_back(typed ? want : p);
	endtask

	function automatic sched_cmd_t mk(edf_pkg::kind_t k, int sl = 0, int rl = 0, int per = 0,
		int dl = 0, int dt = 0, int hd = 0);
		sched_cmd_t c;
		c.kind = k; c.slot = 4'(sl); c.rline = 8'(rl); c.period = 16'(per);
		c.dlimit = 16'(dl); c.dticks = 16'(dt); c.hold = 1'(hd);
		return c;
	endfunction

	function automatic sched_rsp_t rsp(int cur, int sw = 0, int err = 0);
		sched_rsp_t r;
		r = '0; r.cur = 5'(cur); r.sw = 1'(sw); r.err = 1'(err);
		return r;
	endfunction

	function automatic sched_cmd_t rand_cmd();
		sched_cmd_t c;
		int sel;
		c.slot = 4'($urandom); c.rline = 8'($urandom);
		c.period = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		c.dlimit = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
		c.dticks = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		c.hold = ($urandom_range(0, 7) == 0);
		sel = $urandom_range(0, 99);
		if (sel < 40) c.kind = edf_pkg::K_TICK;
		else if (sel < 52) c.kind = edf_pkg::K_CREATE;
		else if (sel < 60) c.kind = edf_pkg::K_DELAY;
		else if (sel < 64) c.kind = edf_pkg::K_DELETE;
		else if (sel < 78) c.kind = edf_pkg::K_MARK;
		else if (sel < 92) c.kind = edf_pkg::K_EXIT;
		else if (sel < 98) c.kind = edf_pkg::K_SWITCH;
		else c.kind = edf_pkg::K_NONE;
		return c;
	endfunction

	sched_cmd_t dir_cmd [$];
	bit         dir_typed [$];
	sched_rsp_t dir_rsp [$];

	task automatic add_row(sched_cmd_t c, bit t = 0, sched_rsp_t r = '0);
		dir_cmd.push_back(c); dir_typed.push_back(t); dir_rsp.push_back(r);
	endtask

	initial begin
		int gap;
		arst_n = 1'b0; start = 1'b0; kind = '0; task_slot = '0; respond_line = '0;
		period_ticks = '0; deadline_limit = '0; delay_ticks = '0; hold_wakeups = 1'b0;
		sh_clock = 0; sh_ticks = 0; sh_active = 0; sh_run = 5'(edf_pkg::NUM_TASKS);
		for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
			sh_status[i] = edf_pkg::ST_FREE; sh_key[i] = 0; sh_bank[i] = 0; sh_rline[i] = 0;
			sh_period[i] = 0; sh_dlimit[i] = 0; sh_entry[i] = 0; sh_smooth[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ops on idle keep the idle task running (switch still reports a switch)
		add_row(mk(edf_pkg::K_NONE), 1, rsp(edf_pkg::NUM_TASKS));
		add_row(mk(edf_pkg::K_DELAY, 0, 0, 0, 0, 5), 1, rsp(edf_pkg::NUM_TASKS));
		add_row(mk(edf_pkg::K_DELETE), 1, rsp(edf_pkg::NUM_TASKS));
		add_row(mk(edf_pkg::K_MARK), 1, rsp(edf_pkg::NUM_TASKS));
		add_row(mk(edf_pkg::K_EXIT), 1, rsp(edf_pkg::NUM_TASKS));
		add_row(mk(edf_pkg::K_SWITCH), 1, rsp(edf_pkg::NUM_TASKS, 1));
		add_row(mk(edf_pkg::K_TICK, 0, 0, 0, 0, 0, 1), 1, rsp(edf_pkg::NUM_TASKS));
		add_row(mk(edf_pkg::K_CREATE, 15, 255, 65535, 65535, 0), 1,
			rsp(edf_pkg::NUM_TASKS));
		add_row(mk(edf_pkg::K_CREATE, 15, 1, 1, 1), 1, rsp(edf_pkg::NUM_TASKS, 0, 1));
		add_row(mk(edf_pkg::K_CREATE, 0, 0, 3, 0));
		add_row(mk(edf_pkg::K_SWITCH));
		add_row(mk(edf_pkg::K_MARK));
		add_row(mk(edf_pkg::K_TICK)); add_row(mk(edf_pkg::K_TICK));
		add_row(mk(edf_pkg::K_EXIT));
		add_row(mk(edf_pkg::K_TICK)); add_row(mk(edf_pkg::K_TICK));
		add_row(mk(edf_pkg::K_TICK, 0, 0, 0, 0, 0, 1));
		add_row(mk(edf_pkg::K_TICK)); add_row(mk(edf_pkg::K_EXIT));
		add_row(mk(edf_pkg::K_DELAY, 0, 0, 0, 0, 65535));
		add_row(mk(edf_pkg::K_DELAY, 0, 0, 0, 0, 0));
		add_row(mk(edf_pkg::K_DELETE));
		add_row(mk(edf_pkg::K_SWITCH));
		add_row(mk(edf_pkg::K_NONE, 15, 255, 65535, 65535, 65535, 1));
		foreach (dir_cmd[i]) begin
			issue_cmd(dir_cmd[i], dir_typed[i], dir_rsp[i]);
		end

		for (int n = 0; n < 1500; n++) begin
			// calm stretch in the middle, then a drain pause once
			if (n == 700) begin
				start <= 1'b0;
				while (pending_rsp.size() != 0) @(posedge clk);
			end
			if (!(n >= 300 && n < 500) && $urandom_range(0, 99) < 22) begin
				start <= 1'b0;
				gap = $urandom_range(1, 30);
				repeat (gap) @(posedge clk);
			end
			issue_cmd(rand_cmd(), 0, '0);
		end
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (2 * edf_pkg::NUM_TASKS + 8) @(posedge clk);
		if (fail_cnt == 0 && pending_rsp.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ edf_task_scheduler_unit.f @@
rtl/core/edf_pkg.sv
rtl/core/edf_ram.sv
rtl/core/edf_task_scheduler_unit.sv
rtl/core/edf_chk.sv
tb/sv/edf_task_scheduler_unit_tb.sv
